FILE: hdl/intlex_pkg.sv
// Package for the integer literal lexer: state and result types, character
// constants and the small per-character helper functions.
// No dependencies; used by intlex_step, integer_literal_lexer_unit and intlex_checker.
package intlex_pkg;

  localparam int unsigned VALUE_WIDTH = 64;
  localparam int unsigned DIGIT_W     = 6;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_ZERO   = 4'd1,
    PH_PREFIX = 4'd2,
    PH_DIGITS = 4'd3,
    PH_SUF1   = 4'd4,
    PH_SUF2   = 4'd5,
    PH_SKIP   = 4'd6
  } phase_e;

  typedef enum logic [1:0] {
    RDX_DEC = 2'd0,
    RDX_BIN = 2'd1,
    RDX_OCT = 2'd2,
    RDX_HEX = 2'd3
  } radix_e;

  typedef enum logic [2:0] {
    TY_I8  = 3'd0,
    TY_I16 = 3'd1,
    TY_I32 = 3'd2,
    TY_I64 = 3'd3,
    TY_U8  = 3'd4,
    TY_U16 = 3'd5,
    TY_U32 = 3'd6,
    TY_U64 = 3'd7
  } int_type_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_SUFX  = 2'd1,
    ST_NO_DIGIT  = 2'd2,
    ST_DEC_POINT = 2'd3
  } status_e;

  typedef struct packed {
    phase_e                 phase;
    radix_e                 radix;
    logic [VALUE_WIDTH-1:0] acc;
    int_type_e              suffix;
  } lex_state_t;

  typedef struct packed {
    logic                   consumed;
    status_e                status;
    int_type_e              int_type;
    logic [VALUE_WIDTH-1:0] value;
  } lex_result_t;

  localparam lex_state_t LEX_RESET = '{
    phase:  PH_IDLE,
    radix:  RDX_DEC,
    acc:    '0,
    suffix: TY_I32
  };

  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_1     = 8'h31;
  localparam logic [7:0] CH_2     = 8'h32;
  localparam logic [7:0] CH_3     = 8'h33;
  localparam logic [7:0] CH_4     = 8'h34;
  localparam logic [7:0] CH_6     = 8'h36;
  localparam logic [7:0] CH_7     = 8'h37;
  localparam logic [7:0] CH_8     = 8'h38;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CH_USCR  = 8'h5F;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LB    = 8'h62;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_LI    = 8'h69;
  localparam logic [7:0] CH_LO    = 8'h6F;
  localparam logic [7:0] CH_LU    = 8'h75;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CH_LZ    = 8'h7A;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] LETTER_A_OFS = 8'd10;

  function automatic logic is_dec(input logic [7:0] c);
    return c inside {[CH_0:CH_9]};
  endfunction

  function automatic logic is_lower(input logic [7:0] c);
    return c inside {[CH_LA:CH_LZ]};
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return is_lower(c) || (c inside {[CH_UA:CH_UZ]});
  endfunction

  function automatic logic is_radix_digit(input logic [7:0] c, input radix_e r);
    logic ok;
    case (r)
      RDX_BIN: ok = (c == CH_0) || (c == CH_1);
      RDX_OCT: ok = c inside {[CH_0:CH_7]};
      RDX_HEX: ok = is_dec(c) || (c inside {[CH_LA:CH_LF]}) || (c inside {[CH_UA:CH_UF]});
      default: ok = is_dec(c);
    endcase
    return ok;
  endfunction

  // Letters map to 10 and up; only reached for valid digits of the radix.
  function automatic logic [DIGIT_W-1:0] digit_value(input logic [7:0] c);
    logic [7:0] d;
    if (is_dec(c)) begin
      d = c - CH_0;
    end else if (is_lower(c)) begin
      d = c - CH_LA + LETTER_A_OFS;
    end else begin
      d = c - CH_UA + LETTER_A_OFS;
    end
    return d[DIGIT_W-1:0];
  endfunction

  // acc * radix as shifts, plus one add for decimal
  function automatic logic [VALUE_WIDTH-1:0] scale(input logic [VALUE_WIDTH-1:0] a,
                                                   input radix_e r);
    logic [VALUE_WIDTH-1:0] s;
    case (r)
      RDX_BIN: s = a << 1;
      RDX_OCT: s = a << 3;
      RDX_HEX: s = a << 4;
      default: s = (a << 3) + (a << 1);
    endcase
    return s;
  endfunction

  function automatic logic [VALUE_WIDTH-1:0] extend(input logic [VALUE_WIDTH-1:0] v,
                                                    input int_type_e t);
    logic [VALUE_WIDTH-1:0] e;
    case (t)
      TY_I8:   e = {{(VALUE_WIDTH-8){v[7]}}, v[7:0]};
      TY_I16:  e = {{(VALUE_WIDTH-16){v[15]}}, v[15:0]};
      TY_I32:  e = {{(VALUE_WIDTH-32){v[31]}}, v[31:0]};
      TY_U8:   e = {{(VALUE_WIDTH-8){1'b0}}, v[7:0]};
      TY_U16:  e = {{(VALUE_WIDTH-16){1'b0}}, v[15:0]};
      TY_U32:  e = {{(VALUE_WIDTH-32){1'b0}}, v[31:0]};
      default: e = v;
    endcase
    return e;
  endfunction

endpackage

FILE: hdl/intlex_step.sv
// One lexer step: next state and optional result for one character.
// Purely combinational; depends on intlex_pkg.
module intlex_step (
  input  logic [7:0]              ch_i,
  input  logic                    first_i,
  input  logic                    eot_i,
  input  intlex_pkg::lex_state_t  state_i,
  output intlex_pkg::lex_state_t  state_o,
  output logic                    emit_o,
  output intlex_pkg::lex_result_t result_o
);

  logic run_digits;
  logic bad_sfx;

  always_comb begin
    state_o    = state_i;
    emit_o     = 1'b0;
    run_digits = 1'b0;
    bad_sfx    = 1'b0;
    result_o   = '{consumed: 1'b0, status: intlex_pkg::ST_OK,
                   int_type: intlex_pkg::TY_I32, value: '0};

    if (eot_i) begin
      case (state_i.phase)
        intlex_pkg::PH_IDLE: begin
        end
        intlex_pkg::PH_PREFIX: begin
          emit_o          = 1'b1;
          result_o.status = intlex_pkg::ST_NO_DIGIT;
        end
        intlex_pkg::PH_SUF1, intlex_pkg::PH_SUF2, intlex_pkg::PH_SKIP: begin
          bad_sfx = 1'b1;
        end
        default: begin
          emit_o         = 1'b1;
          result_o.value = intlex_pkg::extend(state_i.acc, intlex_pkg::TY_I32);
        end
      endcase
    end else if (first_i) begin
      state_o = intlex_pkg::LEX_RESET;
      if (!intlex_pkg::is_dec(ch_i)) begin
        emit_o          = 1'b1;
        result_o.status = intlex_pkg::ST_NO_DIGIT;
      end else begin
        state_o.acc   = intlex_pkg::VALUE_WIDTH'(intlex_pkg::digit_value(ch_i));
        state_o.phase = (ch_i == intlex_pkg::CH_0) ? intlex_pkg::PH_ZERO
                                                   : intlex_pkg::PH_DIGITS;
      end
    end else begin
      case (state_i.phase)
        intlex_pkg::PH_ZERO: begin
          if (ch_i == intlex_pkg::CH_LB) begin
            state_o.radix = intlex_pkg::RDX_BIN;
            state_o.phase = intlex_pkg::PH_PREFIX;
          end else if (ch_i == intlex_pkg::CH_LO) begin
            state_o.radix = intlex_pkg::RDX_OCT;
            state_o.phase = intlex_pkg::PH_PREFIX;
          end else if (ch_i == intlex_pkg::CH_LX) begin
            state_o.radix = intlex_pkg::RDX_HEX;
            state_o.phase = intlex_pkg::PH_PREFIX;
          end else begin
            state_o.phase = intlex_pkg::PH_DIGITS;
            run_digits    = 1'b1;
          end
        end
        intlex_pkg::PH_PREFIX: begin
          if (ch_i == intlex_pkg::CH_USCR) begin
          end else if (intlex_pkg::is_radix_digit(ch_i, state_i.radix)) begin
            state_o.acc   = intlex_pkg::VALUE_WIDTH'(intlex_pkg::digit_value(ch_i));
            state_o.phase = intlex_pkg::PH_DIGITS;
          end else if (ch_i == intlex_pkg::CH_DOT) begin
            emit_o          = 1'b1;
            result_o.status = intlex_pkg::ST_DEC_POINT;
          end else begin
            emit_o          = 1'b1;
            result_o.status = intlex_pkg::ST_NO_DIGIT;
          end
        end
        intlex_pkg::PH_SUF1: begin
          if (ch_i == intlex_pkg::CH_8) begin
            emit_o            = 1'b1;
            result_o.consumed = 1'b1;
            result_o.int_type = state_i.suffix[2] ? intlex_pkg::TY_U8 : intlex_pkg::TY_I8;
            result_o.value    = intlex_pkg::extend(state_i.acc, result_o.int_type);
          end else if (ch_i == intlex_pkg::CH_1) begin
            state_o.suffix = intlex_pkg::int_type_e'({state_i.suffix[2], 2'd1});
            state_o.phase  = intlex_pkg::PH_SUF2;
          end else if (ch_i == intlex_pkg::CH_3) begin
            state_o.suffix = intlex_pkg::int_type_e'({state_i.suffix[2], 2'd2});
            state_o.phase  = intlex_pkg::PH_SUF2;
          end else if (ch_i == intlex_pkg::CH_6) begin
            state_o.suffix = intlex_pkg::int_type_e'({state_i.suffix[2], 2'd3});
            state_o.phase  = intlex_pkg::PH_SUF2;
          end else begin
            bad_sfx = 1'b1;
          end
        end
        intlex_pkg::PH_SUF2: begin
          // second suffix digit: 16, 32, 64
          if ((state_i.suffix[1:0] == 2'd1 && ch_i == intlex_pkg::CH_6) ||
              (state_i.suffix[1:0] == 2'd2 && ch_i == intlex_pkg::CH_2) ||
              (state_i.suffix[1:0] == 2'd3 && ch_i == intlex_pkg::CH_4)) begin
            emit_o            = 1'b1;
            result_o.consumed = 1'b1;
            result_o.int_type = state_i.suffix;
            result_o.value    = intlex_pkg::extend(state_i.acc, state_i.suffix);
          end else begin
            bad_sfx = 1'b1;
          end
        end
        intlex_pkg::PH_SKIP: begin
          bad_sfx = 1'b1;
        end
        intlex_pkg::PH_DIGITS: begin
          run_digits = 1'b1;
        end
        default: begin
        end
      endcase
    end

    if (run_digits) begin
      if (ch_i == intlex_pkg::CH_USCR) begin
      end else if (intlex_pkg::is_radix_digit(ch_i, state_i.radix)) begin
        state_o.acc = intlex_pkg::scale(state_i.acc, state_i.radix) +
                      intlex_pkg::VALUE_WIDTH'(intlex_pkg::digit_value(ch_i));
      end else if (ch_i == intlex_pkg::CH_DOT) begin
        emit_o          = 1'b1;
        result_o.status = intlex_pkg::ST_DEC_POINT;
      end else if (ch_i == intlex_pkg::CH_LI || ch_i == intlex_pkg::CH_LU) begin
        state_o.suffix = (ch_i == intlex_pkg::CH_LU) ? intlex_pkg::TY_U8 : intlex_pkg::TY_I8;
        state_o.phase  = intlex_pkg::PH_SUF1;
      end else begin
        emit_o         = 1'b1;
        result_o.value = intlex_pkg::extend(state_i.acc, intlex_pkg::TY_I32);
      end
    end

    // an unknown suffix swallows letters and digits, then ends the literal
    if (bad_sfx) begin
      if (!eot_i && (intlex_pkg::is_letter(ch_i) || intlex_pkg::is_dec(ch_i))) begin
        state_o.phase = intlex_pkg::PH_SKIP;
      end else begin
        emit_o          = 1'b1;
        result_o.status = intlex_pkg::ST_BAD_SUFX;
        result_o.value  = intlex_pkg::extend(state_i.acc, intlex_pkg::TY_I32);
      end
    end

    if (emit_o) begin
      state_o = intlex_pkg::LEX_RESET;
    end
  end

endmodule

FILE: hdl/integer_literal_lexer_unit.sv
// Top level of the integer literal lexer: input register, lexer state,
// result register. Depends on intlex_pkg and intlex_step.
//
//  channel   | dir | tdata              | tuser
//  ----------+-----+--------------------+---------------------------------------
//  s_axis    | in  | [7:0] ch           | [0] first, [1] end_of_text
//  m_axis    | out | [63:0] value       | [2:0] int_type, [4:3] status, [5] consumed
//
// One character request per cycle while no result is stalled. A request waits
// in the input register, then one lexer step updates the state and, if the
// literal ends, loads the result register, which drives m_axis. The loop that
// sets the rate is the state update (64-bit shift-add accumulate). Reset
// clears the lexer state to idle / decimal / zero / i32 and empties both
// registers. When a result waits and m_axis_tready is low, the step holds;
// once the input register holds a request, it holds too and
// s_axis_tready drops.
module integer_literal_lexer_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [7:0]                         s_axis_tdata,   // [7:0] ch
  input  logic [1:0]                         s_axis_tuser,   // [0] first, [1] end_of_text
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [intlex_pkg::VALUE_WIDTH-1:0] m_axis_tdata,   // [63:0] value
  output logic [5:0]                         m_axis_tuser    // [2:0] int_type,
                                                             // [4:3] status, [5] consumed
);

  // input register
  logic       in_valid_q, in_valid_d;
  logic [7:0] ch_q;
  logic       first_q;
  logic       eot_q;

  // lexer state and result register
  intlex_pkg::lex_state_t  state_q, state_d;
  intlex_pkg::lex_result_t res_q;
  intlex_pkg::lex_result_t step_res;
  logic                    step_emit;
  logic                    out_valid_q, out_valid_d;

  logic step_go;
  logic in_take;

  // the step runs when its result (if any) has a free slot
  assign step_go = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || step_go;
  assign in_take = s_axis_tvalid && s_axis_tready;

  assign in_valid_d  = in_take ? 1'b1 : (in_valid_q && !step_go);
  assign out_valid_d = step_go ? step_emit : (out_valid_q && !m_axis_tready);

  intlex_step u_step (
    .ch_i     (ch_q),
    .first_i  (first_q),
    .eot_i    (eot_q),
    .state_i  (state_q),
    .state_o  (state_d),
    .emit_o   (step_emit),
    .result_o (step_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= intlex_pkg::LEX_RESET;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (step_go) begin
        state_q <= state_d;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      ch_q    <= s_axis_tdata;
      first_q <= s_axis_tuser[0];
      eot_q   <= s_axis_tuser[1];
    end
    if (step_go && step_emit) begin
      res_q <= step_res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = res_q.value;
  assign m_axis_tuser  = {res_q.consumed, res_q.status, res_q.int_type};

endmodule

FILE: hdl/intlex_checker.sv
// Port-level checks for integer_literal_lexer_unit, and the bind that attaches them.
// Depends on intlex_pkg.
module intlex_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               m_axis_tvalid,
  input logic                               m_axis_tready,
  input logic [intlex_pkg::VALUE_WIDTH-1:0] m_axis_tdata,
  input logic [5:0]                         m_axis_tuser
);

  // a stalled result stays and holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result dropped or changed while stalled");

  // no-digit and decimal-point results carry a zero value with the default type
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser[4:3] == intlex_pkg::ST_NO_DIGIT ||
                      m_axis_tuser[4:3] == intlex_pkg::ST_DEC_POINT) |->
      m_axis_tdata == '0 && m_axis_tuser[2:0] == intlex_pkg::TY_I32 && !m_axis_tuser[5])
    else $error("error result with nonzero value or wrong type");

  // only a completed suffix consumes the ending character
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[5] |-> m_axis_tuser[4:3] == intlex_pkg::ST_OK)
    else $error("consumed character with non-ok status");

  // default type results are sign extended from bit 31
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[2:0] == intlex_pkg::TY_I32 |->
      m_axis_tdata[63:31] == '0 || m_axis_tdata[63:31] == '1)
    else $error("i32 result not sign extended");

endmodule

bind integer_literal_lexer_unit intlex_checker u_intlex_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

FILE: tb/sv/integer_literal_lexer_unit_tb.sv
// Self-checking bench for integer_literal_lexer_unit: character requests go
// in on s_axis, lexed literals come out on m_axis and are checked against a
// behavioral lexer kept here. Depends on intlex_pkg and the unit's RTL.
module integer_literal_lexer_unit_tb;

  localparam int unsigned STUCK_LIMIT = 3000;  // cycles without any request moving
  localparam int unsigned HOLD_CYCLES = 150;   // long sink stall, fills the pipe
  localparam int unsigned LEX_ITEMS   = 1850;
  localparam logic [7:0]  CH_SPACE    = 8'h20;
  localparam string       PUNCT       = " ;,)+-*";

  typedef struct {
    logic [7:0] ch;
    logic       first;
    logic       eot;
  } char_req_t;

  typedef struct {
    logic [63:0]           value;
    intlex_pkg::int_type_e int_type;
    intlex_pkg::status_e   status;
    logic                  consumed;
  } token_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // [7:0] ch
  logic [1:0]  s_axis_tuser = '0;   // [0] first, [1] end_of_text
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;        // [63:0] value
  logic [5:0]  m_axis_tuser;        // [2:0] int_type, [4:3] status, [5] consumed

  char_req_t   char_queue[$];
  token_t      expected_tokens[$];
  int          n_total;
  int          n_counted;
  int          n_sent = 0;
  int          n_accepted = 0;
  int          n_tokens = 0;
  int          n_errors = 0;

  // behavioral lexer state
  intlex_pkg::phase_e    lx_phase  = intlex_pkg::PH_IDLE;
  intlex_pkg::radix_e    lx_radix  = intlex_pkg::RDX_DEC;
  logic [63:0]           lx_acc    = '0;
  intlex_pkg::int_type_e lx_suffix = intlex_pkg::TY_I32;

  integer_literal_lexer_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Behavioral lexer
  // ---------------------------------------------------------------------
  function automatic bit is_digit10(logic [7:0] c);
    return c >= intlex_pkg::CH_0 && c <= intlex_pkg::CH_9;
  endfunction

  function automatic bit is_alnum(logic [7:0] c);
    return is_digit10(c) || (c >= intlex_pkg::CH_LA && c <= intlex_pkg::CH_LZ) ||
           (c >= intlex_pkg::CH_UA && c <= intlex_pkg::CH_UZ);
  endfunction

  function automatic bit fits_radix(logic [7:0] c, intlex_pkg::radix_e r);
    case (r)
      intlex_pkg::RDX_BIN: return c == intlex_pkg::CH_0 || c == intlex_pkg::CH_1;
      intlex_pkg::RDX_OCT: return c >= intlex_pkg::CH_0 && c <= intlex_pkg::CH_7;
      intlex_pkg::RDX_HEX:
        return is_digit10(c) || (c >= intlex_pkg::CH_LA && c <= intlex_pkg::CH_LF) ||
               (c >= intlex_pkg::CH_UA && c <= intlex_pkg::CH_UF);
      default: return is_digit10(c);
    endcase
  endfunction

  function automatic logic [63:0] digit_of(logic [7:0] c);
    if (is_digit10(c)) return 64'(c - intlex_pkg::CH_0);
    if (c >= intlex_pkg::CH_LA) return 64'(c - intlex_pkg::CH_LA) + 64'd10;
    return 64'(c - intlex_pkg::CH_UA) + 64'd10;
  endfunction

  function automatic logic [63:0] base_of(intlex_pkg::radix_e r);
    case (r)
      intlex_pkg::RDX_BIN: return 64'd2;
      intlex_pkg::RDX_OCT: return 64'd8;
      intlex_pkg::RDX_HEX: return 64'd16;
      default:             return 64'd10;
    endcase
  endfunction

  // truncate to the literal's type, then widen back to 64 bits
  function automatic logic [63:0] fit_to_type(logic [63:0] v, intlex_pkg::int_type_e t);
    case (t)
      intlex_pkg::TY_I8:  return {{56{v[7]}}, v[7:0]};
      intlex_pkg::TY_I16: return {{48{v[15]}}, v[15:0]};
      intlex_pkg::TY_I32: return {{32{v[31]}}, v[31:0]};
      intlex_pkg::TY_U8:  return {56'd0, v[7:0]};
      intlex_pkg::TY_U16: return {48'd0, v[15:0]};
      intlex_pkg::TY_U32: return {32'd0, v[31:0]};
      default:            return v;
    endcase
  endfunction

  task automatic finish_token(logic [63:0] v, intlex_pkg::int_type_e t,
                              intlex_pkg::status_e s, logic used);
    token_t tok;
    tok.value    = v;
    tok.int_type = t;
    tok.status   = s;
    tok.consumed = used;
    expected_tokens = {expected_tokens, tok};
    lx_phase  = intlex_pkg::PH_IDLE;
    lx_radix  = intlex_pkg::RDX_DEC;
    lx_acc    = '0;
    lx_suffix = intlex_pkg::TY_I32;
  endtask

  // an i/u that does not form a suffix eats alphanumerics, then ends the literal
  task automatic bad_suffix(logic [7:0] c, logic eot);
    if (!eot && is_alnum(c)) begin
      lx_phase = intlex_pkg::PH_SKIP;
    end else begin
      finish_token(fit_to_type(lx_acc, intlex_pkg::TY_I32), intlex_pkg::TY_I32,
                   intlex_pkg::ST_BAD_SUFX, 1'b0);
    end
  endtask

  task automatic lex_char(logic [7:0] c, logic first, logic eot);
    logic      in_digits;
    logic [7:0] want;
    in_digits = 1'b0;
    if (eot) begin
      case (lx_phase)
        intlex_pkg::PH_IDLE:   ;
        intlex_pkg::PH_PREFIX:
          finish_token('0, intlex_pkg::TY_I32, intlex_pkg::ST_NO_DIGIT, 1'b0);
        intlex_pkg::PH_SUF1, intlex_pkg::PH_SUF2, intlex_pkg::PH_SKIP: bad_suffix(c, 1'b1);
        default:
          finish_token(fit_to_type(lx_acc, intlex_pkg::TY_I32), intlex_pkg::TY_I32,
                       intlex_pkg::ST_OK, 1'b0);
      endcase
      return;
    end
    if (first) begin
      // a new first drops whatever literal was in flight
      lx_phase  = intlex_pkg::PH_IDLE;
      lx_radix  = intlex_pkg::RDX_DEC;
      lx_acc    = '0;
      lx_suffix = intlex_pkg::TY_I32;
      if (!is_digit10(c)) begin
        finish_token('0, intlex_pkg::TY_I32, intlex_pkg::ST_NO_DIGIT, 1'b0);
      end else begin
        lx_acc   = digit_of(c);
        lx_phase = (c == intlex_pkg::CH_0) ? intlex_pkg::PH_ZERO : intlex_pkg::PH_DIGITS;
      end
      return;
    end
    case (lx_phase)
      intlex_pkg::PH_ZERO: begin
        if (c == intlex_pkg::CH_LB || c == intlex_pkg::CH_LO || c == intlex_pkg::CH_LX) begin
          lx_radix = (c == intlex_pkg::CH_LB) ? intlex_pkg::RDX_BIN :
                     (c == intlex_pkg::CH_LO) ? intlex_pkg::RDX_OCT : intlex_pkg::RDX_HEX;
          lx_phase = intlex_pkg::PH_PREFIX;
        end else begin
          lx_phase  = intlex_pkg::PH_DIGITS;
          in_digits = 1'b1;
        end
      end
      intlex_pkg::PH_PREFIX: begin
        if (c == intlex_pkg::CH_USCR) begin
        end else if (fits_radix(c, lx_radix)) begin
          lx_acc   = digit_of(c);
          lx_phase = intlex_pkg::PH_DIGITS;
        end else if (c == intlex_pkg::CH_DOT) begin
          finish_token('0, intlex_pkg::TY_I32, intlex_pkg::ST_DEC_POINT, 1'b0);
        end else begin
          finish_token('0, intlex_pkg::TY_I32, intlex_pkg::ST_NO_DIGIT, 1'b0);
        end
      end
      intlex_pkg::PH_SUF1: begin
        if (c == intlex_pkg::CH_8) begin
          finish_token(fit_to_type(lx_acc, lx_suffix[2] ? intlex_pkg::TY_U8 : intlex_pkg::TY_I8),
                       lx_suffix[2] ? intlex_pkg::TY_U8 : intlex_pkg::TY_I8,
                       intlex_pkg::ST_OK, 1'b1);
        end else if (c == intlex_pkg::CH_1) begin
          lx_suffix = lx_suffix[2] ? intlex_pkg::TY_U16 : intlex_pkg::TY_I16;
          lx_phase  = intlex_pkg::PH_SUF2;
        end else if (c == intlex_pkg::CH_3) begin
          lx_suffix = lx_suffix[2] ? intlex_pkg::TY_U32 : intlex_pkg::TY_I32;
          lx_phase  = intlex_pkg::PH_SUF2;
        end else if (c == intlex_pkg::CH_6) begin
          lx_suffix = lx_suffix[2] ? intlex_pkg::TY_U64 : intlex_pkg::TY_I64;
          lx_phase  = intlex_pkg::PH_SUF2;
        end else begin
          bad_suffix(c, 1'b0);
        end
      end
      intlex_pkg::PH_SUF2: begin
        case (lx_suffix)
          intlex_pkg::TY_I16, intlex_pkg::TY_U16: want = intlex_pkg::CH_6;
          intlex_pkg::TY_I32, intlex_pkg::TY_U32: want = intlex_pkg::CH_2;
          default:                                want = intlex_pkg::CH_4;
        endcase
        if (c == want) begin
          finish_token(fit_to_type(lx_acc, lx_suffix), lx_suffix, intlex_pkg::ST_OK, 1'b1);
        end else begin
          bad_suffix(c, 1'b0);
        end
      end
      intlex_pkg::PH_SKIP:   bad_suffix(c, 1'b0);
      intlex_pkg::PH_DIGITS: in_digits = 1'b1;
      default:   ;  // idle: stray character, ignored
    endcase
    if (in_digits) begin
      if (c == intlex_pkg::CH_USCR) begin
      end else if (fits_radix(c, lx_radix)) begin
        lx_acc = lx_acc * base_of(lx_radix) + digit_of(c);
      end else if (c == intlex_pkg::CH_DOT) begin
        finish_token('0, intlex_pkg::TY_I32, intlex_pkg::ST_DEC_POINT, 1'b0);
      end else if (c == intlex_pkg::CH_LI || c == intlex_pkg::CH_LU) begin
        lx_suffix = (c == intlex_pkg::CH_LU) ? intlex_pkg::TY_U8 : intlex_pkg::TY_I8;
        lx_phase  = intlex_pkg::PH_SUF1;
      end else begin
        finish_token(fit_to_type(lx_acc, intlex_pkg::TY_I32), intlex_pkg::TY_I32,
                     intlex_pkg::ST_OK, 1'b0);
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  task automatic push_char(logic [7:0] c, logic first, logic eot, bit counted);
    char_req_t r;
    r.ch    = c;
    r.first = first;
    r.eot   = eot;
    char_queue = {char_queue, r};
    if (counted) n_counted++;
  endtask

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) push_char(s[i], 1'b0, 1'b0, 1'b1);
  endtask

  function automatic logic [7:0] rand_alnum();
    int k;
    k = $urandom_range(61);
    if (k < 10) return intlex_pkg::CH_0 + 8'(k);
    if (k < 36) return intlex_pkg::CH_LA + 8'(k - 10);
    return intlex_pkg::CH_UA + 8'(k - 36);
  endfunction

  function automatic logic [7:0] rand_digit(intlex_pkg::radix_e r);
    int k;
    k = $urandom_range(int'(base_of(r)) - 1);
    if (k < 10) return intlex_pkg::CH_0 + 8'(k);
    return ($urandom_range(1) ? intlex_pkg::CH_UA : intlex_pkg::CH_LA) + 8'(k - 10);
  endfunction

  // one literal with random content, mostly well formed
  task automatic push_literal();
    intlex_pkg::radix_e r;
    int     ndig;
    int     pick;
    int     t;
    string  sfx;
    r = intlex_pkg::RDX_DEC;
    pick = $urandom_range(99);
    if (pick < 45) begin
      r = (pick < 15) ? intlex_pkg::RDX_BIN :
          (pick < 27) ? intlex_pkg::RDX_OCT : intlex_pkg::RDX_HEX;
      push_char(intlex_pkg::CH_0, 1'b1, 1'b0, 1'b1);
      push_char(r == intlex_pkg::RDX_BIN ? intlex_pkg::CH_LB :
                r == intlex_pkg::RDX_OCT ? intlex_pkg::CH_LO : intlex_pkg::CH_LX,
                1'b0, 1'b0, 1'b1);
      if ($urandom_range(9) == 0) push_char(intlex_pkg::CH_USCR, 1'b0, 1'b0, 1'b1);
      ndig = ($urandom_range(12) == 0) ? 0 : $urandom_range(1, 6);
    end else begin
      push_char($urandom_range(9) == 0 ? intlex_pkg::CH_0 : rand_digit(intlex_pkg::RDX_DEC),
                1'b1, 1'b0, 1'b1);
      ndig = $urandom_range(0, 5);
    end
    // long runs can wrap the 64-bit accumulator
    if ($urandom_range(7) == 0) ndig = $urandom_range(16, 70);
    for (int i = 0; i < ndig; i++) begin
      if ($urandom_range(9) == 0) push_char(intlex_pkg::CH_USCR, 1'b0, 1'b0, 1'b1);
      if ($urandom_range(40) == 0) push_char(8'($urandom_range(255)), 1'b0, 1'b0, 1'b1);
      else push_char(rand_digit(r), 1'b0, 1'b0, 1'b1);
    end
    pick = $urandom_range(99);
    if (pick < 45) begin
      t = $urandom_range(7);
      sfx = (t >= 4) ? "u" : "i";
      case (t % 4)
        0:       sfx = {sfx, "8"};
        1:       sfx = {sfx, "16"};
        2:       sfx = {sfx, "32"};
        default: sfx = {sfx, "64"};
      endcase
      push_text(sfx);
    end else if (pick < 60) begin
      // broken suffix: i/u, maybe a valid width start, then alphanumerics
      push_char($urandom_range(1) ? intlex_pkg::CH_LU : intlex_pkg::CH_LI, 1'b0, 1'b0, 1'b1);
      if ($urandom_range(1)) begin
        push_char($urandom_range(1) ? intlex_pkg::CH_1 : intlex_pkg::CH_3, 1'b0, 1'b0, 1'b1);
      end
      repeat ($urandom_range(3)) push_char(rand_alnum(), 1'b0, 1'b0, 1'b1);
    end
    pick = $urandom_range(99);
    if (pick < 35) begin
      push_char(PUNCT[$urandom_range(PUNCT.len() - 1)], 1'b0, 1'b0, 1'b1);
    end else if (pick < 52) begin
      push_char(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1, 1'b1);
    end else if (pick < 62) begin
      push_char(intlex_pkg::CH_DOT, 1'b0, 1'b0, 1'b1);
    end else if (pick < 75) begin
      push_char(8'($urandom_range(255)), 1'b0, 1'b0, 1'b1);
    end else if (pick < 88) begin
      // next literal's first drops this one
    end else begin
      push_char(8'($urandom_range(255)), 1'b1, 1'b0, 1'b1);
    end
  endtask

  // ---------------------------------------------------------------------
  // Driver: next character request from the queue, random gaps
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin
    char_req_t nxt;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        lex_char(s_axis_tdata, s_axis_tuser[0], s_axis_tuser[1]);
        n_accepted <= n_accepted + 1;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        // requests 600..899 go back to back
        if (char_queue.size() != 0 &&
            ((n_sent >= 600 && n_sent < 900) || $urandom_range(99) >= 15)) begin
          nxt = char_queue.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= nxt.ch;
          s_axis_tuser  <= {nxt.eot, nxt.first};
          n_sent        <= n_sent + 1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Sink: random stalls, one long hold-off, a stretch always ready
  // ---------------------------------------------------------------------
  int  rx_cycles = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      rx_cycles <= rx_cycles + 1;
      if (!hold_done && n_tokens >= 40) begin
        hold_done     <= 1'b1;
        hold_left     <= HOLD_CYCLES;
        m_axis_tready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left     <= hold_left - 1;
        m_axis_tready <= 1'b0;
      end else if (rx_cycles >= 1500 && rx_cycles < 2300) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= 15);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: each result against the oldest expected token
  // ---------------------------------------------------------------------
  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    $display("mismatch at result %0d, %s: got %0h, expected %0h", n_tokens, field, got, want);
    n_errors++;
  endtask

  always @(posedge clk_i) begin
    token_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      n_tokens <= n_tokens + 1;
      if (expected_tokens.size() == 0) begin
        report_mismatch("unexpected result, value", m_axis_tdata, '0);
      end else begin
        want = expected_tokens.pop_front();
        if (m_axis_tdata !== want.value) report_mismatch("value", m_axis_tdata, want.value);
        if (m_axis_tuser[2:0] !== want.int_type)
          report_mismatch("int_type", 64'(m_axis_tuser[2:0]), 64'(want.int_type));
        if (m_axis_tuser[4:3] !== want.status)
          report_mismatch("status", 64'(m_axis_tuser[4:3]), 64'(want.status));
        if (m_axis_tuser[5] !== want.consumed)
          report_mismatch("consumed", 64'(m_axis_tuser[5]), 64'(want.consumed));
      end
    end
  end

  // watchdog: no request moving on either side for too long
  int stuck_cycles = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        stuck_cycles <= 0;
      end else begin
        stuck_cycles <= stuck_cycles + 1;
      end
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Sequence: directed cases, random literals, reset, drain, verdict
  // ---------------------------------------------------------------------
  initial begin
    n_counted = 0;
    push_char(intlex_pkg::CH_LZ, 1'b0, 1'b0, 1'b0);  // stray char while idle
    push_char(8'h00, 1'b1, 1'b1, 1'b1);        // end of text while idle, first set
    push_char(8'hFF, 1'b1, 1'b0, 1'b1);        // first on a non-digit
    push_char(intlex_pkg::CH_9, 1'b1, 1'b0, 1'b1);   // dropped by the next first
    push_char(intlex_pkg::CH_0, 1'b1, 1'b0, 1'b1);   // 0x_Ff. -> decimal point
    push_text("x_Ff.");
    push_char(intlex_pkg::CH_0, 1'b1, 1'b0, 1'b1);   // 0o then NUL -> no digit
    push_char(intlex_pkg::CH_LO, 1'b0, 1'b0, 1'b1);
    push_char(8'h00, 1'b0, 1'b0, 1'b1);
    push_char(intlex_pkg::CH_2, 1'b1, 1'b0, 1'b1);   // 200i8 wraps negative
    push_text("00i8");
    push_char(intlex_pkg::CH_7, 1'b1, 1'b0, 1'b1);   // 7i9 then end of text: bad suffix
    push_text("i9");
    push_char(8'hA5, 1'b0, 1'b1, 1'b1);
    push_char(intlex_pkg::CH_0, 1'b1, 1'b0, 1'b1);   // 0b then end of text: no digit
    push_char(intlex_pkg::CH_LB, 1'b0, 1'b0, 1'b1);
    push_char(8'h5A, 1'b0, 1'b1, 1'b1);
    push_char(intlex_pkg::CH_1, 1'b1, 1'b0, 1'b1);   // 1u64 then a space
    push_text("u64 ");
    while (n_counted < LEX_ITEMS) begin
      if ($urandom_range(9) == 0) begin
        repeat ($urandom_range(1, 3)) push_char(8'($urandom_range(255)), 1'b0, 1'b0, 1'b0);
      end
      push_literal();
    end
    push_char(CH_SPACE, 1'b0, 1'b1, 1'b1);     // close whatever is still open
    n_total = char_queue.size();

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(negedge clk_i); while (n_accepted != n_total || expected_tokens.size() != 0);
    repeat (16) @(negedge clk_i);
    if (n_errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/intlex_pkg.sv
hdl/intlex_step.sv
hdl/integer_literal_lexer_unit.sv
hdl/intlex_checker.sv
tb/sv/integer_literal_lexer_unit_tb.sv
